// ===== rtl/gpc_pkg.sv =====
`timescale 1ns / 1ps

package gpc_pkg;

  localparam int WORD_BITS = 32;
  localparam int OUT_PINS  = 54;
  localparam int MAX_PINS  = 64;
  localparam int DET_COUNT = 6;
  localparam int FSEL_BITS = 3;
  localparam int PULL_BITS = 2;

  // Item kinds
  localparam logic [1:0] FUNC_READ   = 2'd0;
  localparam logic [1:0] FUNC_WRITE  = 2'd1;
  localparam logic [1:0] FUNC_SAMPLE = 2'd2;

  // Register word indices
  localparam logic [5:0] REG_FSEL0   = 6'd0;
  localparam logic [5:0] REG_FSEL1   = 6'd1;
  localparam logic [5:0] REG_FSEL2   = 6'd2;
  localparam logic [5:0] REG_FSEL3   = 6'd3;
  localparam logic [5:0] REG_FSEL4   = 6'd4;
  localparam logic [5:0] REG_FSEL5   = 6'd5;
  localparam logic [5:0] REG_SET_LO  = 6'd7;
  localparam logic [5:0] REG_SET_HI  = 6'd8;
  localparam logic [5:0] REG_CLR_LO  = 6'd10;
  localparam logic [5:0] REG_CLR_HI  = 6'd11;
  localparam logic [5:0] REG_LEV_LO  = 6'd13;
  localparam logic [5:0] REG_LEV_HI  = 6'd14;
  localparam logic [5:0] REG_EVS_LO  = 6'd16;
  localparam logic [5:0] REG_EVS_HI  = 6'd17;
  localparam logic [5:0] REG_REN_LO  = 6'd19;
  localparam logic [5:0] REG_REN_HI  = 6'd20;
  localparam logic [5:0] REG_FEN_LO  = 6'd22;
  localparam logic [5:0] REG_FEN_HI  = 6'd23;
  localparam logic [5:0] REG_HEN_LO  = 6'd25;
  localparam logic [5:0] REG_HEN_HI  = 6'd26;
  localparam logic [5:0] REG_LEN_LO  = 6'd28;
  localparam logic [5:0] REG_LEN_HI  = 6'd29;
  localparam logic [5:0] REG_AREN_LO = 6'd31;
  localparam logic [5:0] REG_AREN_HI = 6'd32;
  localparam logic [5:0] REG_AFEN_LO = 6'd34;
  localparam logic [5:0] REG_AFEN_HI = 6'd35;
  localparam logic [5:0] REG_PCODE   = 6'd37;
  localparam logic [5:0] REG_PCLK_LO = 6'd38;
  localparam logic [5:0] REG_PCLK_HI = 6'd39;

  // Detect enable slots
  localparam logic [2:0] DET_RISE  = 3'd0;
  localparam logic [2:0] DET_FALL  = 3'd1;
  localparam logic [2:0] DET_HIGH  = 3'd2;
  localparam logic [2:0] DET_LOW   = 3'd3;
  localparam logic [2:0] DET_ARISE = 3'd4;
  localparam logic [2:0] DET_AFALL = 3'd5;

  // Decoded register kinds
  localparam logic [3:0] KIND_NONE  = 4'd0;
  localparam logic [3:0] KIND_FSEL  = 4'd1;
  localparam logic [3:0] KIND_SET   = 4'd2;
  localparam logic [3:0] KIND_CLR   = 4'd3;
  localparam logic [3:0] KIND_LEV   = 4'd4;
  localparam logic [3:0] KIND_EVS   = 4'd5;
  localparam logic [3:0] KIND_DET   = 4'd6;
  localparam logic [3:0] KIND_PCODE = 4'd7;
  localparam logic [3:0] KIND_PCLK  = 4'd8;

  localparam logic [2:0] FSEL_OUTPUT = 3'd1;
  localparam logic [1:0] PULL_DOWN   = 2'd1;
  localparam logic [1:0] PULL_UP     = 2'd2;

  typedef struct packed {
    logic [1:0]          func;
    logic [5:0]          reg_index;
    logic [31:0]         write_data;
    logic [OUT_PINS-1:0] pin_levels;
  } req_t;

  typedef struct packed {
    logic [31:0]         read_data;
    logic [OUT_PINS-1:0] drive_level;
    logic [OUT_PINS-1:0] drive_enable;
    logic [OUT_PINS-1:0] pull_up_mask;
    logic [OUT_PINS-1:0] pull_down_mask;
    logic                event_pending;
  } rsp_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

// ===== rtl/gpc_regfile.sv =====
`timescale 1ns / 1ps

module gpc_regfile
  import gpc_pkg::*;
#(
  parameter int PIN_COUNT = 54
) (
  input  logic clk,
  input  logic rst,
  input  logic step,
  input  req_t item,
  output rsp_t result
);

  localparam int FSEL_PAD = 8 * 30;

  // Register state
  logic [PIN_COUNT-1:0]           latch;
  logic [PIN_COUNT-1:0]           status;
  logic [PIN_COUNT-1:0]           last;
  logic [PIN_COUNT-1:0]           det [DET_COUNT];
  logic [1:0]                     pend;
  logic [FSEL_BITS*PIN_COUNT-1:0] fsel;
  logic [PULL_BITS*PIN_COUNT-1:0] pull;

  logic [PIN_COUNT-1:0]           latch_next;
  logic [PIN_COUNT-1:0]           status_next;
  logic [PIN_COUNT-1:0]           last_next;
  logic [PIN_COUNT-1:0]           det_next [DET_COUNT];
  logic [1:0]                     pend_next;
  logic [FSEL_BITS*PIN_COUNT-1:0] fsel_next;
  logic [PULL_BITS*PIN_COUNT-1:0] pull_next;

  logic [3:0]           kind;
  logic                 upper;
  logic [2:0]           det_sel;
  logic                 is_wr;
  logic                 is_rd;
  logic                 is_smp;
  logic [63:0]          wide_data;
  logic [PIN_COUNT-1:0] pins;
  logic [63:0]          keep64;
  logic [PIN_COUNT-1:0] now;
  logic [PIN_COUNT-1:0] hit;
  logic [PIN_COUNT-1:0] src;
  logic [63:0]          src64;
  logic [FSEL_PAD-1:0]  fsel_pad;
  logic [31:0]          read_word;
  logic [PIN_COUNT-1:0] en_vec;
  logic [PIN_COUNT-1:0] up_vec;
  logic [PIN_COUNT-1:0] dn_vec;
  logic [63:0]          latch64;
  logic [63:0]          en64;
  logic [63:0]          up64;
  logic [63:0]          dn64;

  assign is_rd  = item.func == FUNC_READ;
  assign is_wr  = item.func == FUNC_WRITE;
  assign is_smp = item.func == FUNC_SAMPLE;

  // Register decode
  always_comb begin
    unique case (item.reg_index) inside
      REG_FSEL0, REG_FSEL1, REG_FSEL2, REG_FSEL3, REG_FSEL4, REG_FSEL5: kind = KIND_FSEL;
      REG_SET_LO, REG_SET_HI:   kind = KIND_SET;
      REG_CLR_LO, REG_CLR_HI:   kind = KIND_CLR;
      REG_LEV_LO, REG_LEV_HI:   kind = KIND_LEV;
      REG_EVS_LO, REG_EVS_HI:   kind = KIND_EVS;
      REG_REN_LO, REG_REN_HI, REG_FEN_LO, REG_FEN_HI, REG_HEN_LO, REG_HEN_HI,
      REG_LEN_LO, REG_LEN_HI, REG_AREN_LO, REG_AREN_HI, REG_AFEN_LO,
      REG_AFEN_HI:              kind = KIND_DET;
      REG_PCODE:                kind = KIND_PCODE;
      REG_PCLK_LO, REG_PCLK_HI: kind = KIND_PCLK;
      default:                  kind = KIND_NONE;
    endcase
  end

  always_comb begin
    unique case (item.reg_index) inside
      REG_SET_HI, REG_CLR_HI, REG_LEV_HI, REG_EVS_HI, REG_REN_HI, REG_FEN_HI,
      REG_HEN_HI, REG_LEN_HI, REG_AREN_HI, REG_AFEN_HI, REG_PCLK_HI: upper = 1'b1;
      default: upper = 1'b0;
    endcase
  end

  always_comb begin
    unique case (item.reg_index) inside
      REG_FEN_LO, REG_FEN_HI:   det_sel = DET_FALL;
      REG_HEN_LO, REG_HEN_HI:   det_sel = DET_HIGH;
      REG_LEN_LO, REG_LEN_HI:   det_sel = DET_LOW;
      REG_AREN_LO, REG_AREN_HI: det_sel = DET_ARISE;
      REG_AFEN_LO, REG_AFEN_HI: det_sel = DET_AFALL;
      default:                  det_sel = DET_RISE;
    endcase
  end

  // Spread the data word onto its half of the pin vector
  assign wide_data = upper ? {item.write_data, 32'h0} : {32'h0, item.write_data};
  assign pins      = wide_data[PIN_COUNT-1:0];
  assign keep64    = upper ? 64'h0000_0000_ffff_ffff : 64'hffff_ffff_0000_0000;

  // Level sampling and event detection
  always_comb begin
    logic [63:0] lev64;
    lev64 = 64'(item.pin_levels);
    now   = lev64[PIN_COUNT-1:0];
    hit   = ((det[DET_RISE] | det[DET_ARISE]) & now & ~last)
          | ((det[DET_FALL] | det[DET_AFALL]) & ~now & last)
          | (det[DET_HIGH] & now)
          | (det[DET_LOW] & ~now);
  end

  always_comb begin
    latch_next  = latch;
    status_next = status;
    last_next   = last;
    pend_next   = pend;
    for (int d = 0; d < DET_COUNT; d++) begin
      det_next[d] = det[d];
    end
    if (is_wr) begin
      case (kind)
        KIND_SET:   latch_next  = latch | pins;
        KIND_CLR:   latch_next  = latch & ~pins;
        KIND_EVS:   status_next = status & ~pins;
        KIND_DET:   det_next[det_sel] = (det[det_sel] & keep64[PIN_COUNT-1:0]) | pins;
        KIND_PCODE: pend_next   = item.write_data[1:0];
        default:    ;
      endcase
    end
    if (is_smp) begin
      status_next = status | hit;
      last_next   = now;
    end
  end

  // Per-pin function select and pull latches
  for (genvar p = 0; p < PIN_COUNT; p++) begin : g_pin
    localparam int FS_WORD = p / 10;
    localparam int FS_SLOT = p % 10;
    if (p < 60) begin : g_fs
      assign fsel_next[FSEL_BITS*p +: FSEL_BITS] =
        (is_wr && kind == KIND_FSEL && item.reg_index == 6'(FS_WORD))
          ? item.write_data[FSEL_BITS*FS_SLOT +: FSEL_BITS]
          : fsel[FSEL_BITS*p +: FSEL_BITS];
    end else begin : g_fs_fixed
      assign fsel_next[FSEL_BITS*p +: FSEL_BITS] = fsel[FSEL_BITS*p +: FSEL_BITS];
    end
    assign pull_next[PULL_BITS*p +: PULL_BITS] = (is_wr && kind == KIND_PCLK && pins[p])
      ? pend : pull[PULL_BITS*p +: PULL_BITS];
    assign en_vec[p] = fsel_next[FSEL_BITS*p +: FSEL_BITS] == FSEL_OUTPUT;
    assign up_vec[p] = pull_next[PULL_BITS*p +: PULL_BITS] == PULL_UP;
    assign dn_vec[p] = pull_next[PULL_BITS*p +: PULL_BITS] == PULL_DOWN;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      latch  <= '0;
      status <= '0;
      last   <= '0;
      pend   <= '0;
      fsel   <= '0;
      pull   <= '0;
      for (int d = 0; d < DET_COUNT; d++) begin
        det[d] <= '0;
      end
    end else if (step) begin
      latch  <= latch_next;
      status <= status_next;
      last   <= last_next;
      pend   <= pend_next;
      fsel   <= fsel_next;
      pull   <= pull_next;
      for (int d = 0; d < DET_COUNT; d++) begin
        det[d] <= det_next[d];
      end
    end
  end

  // Read path, taken from the state before the item
  assign fsel_pad = FSEL_PAD'(fsel);

  always_comb begin
    case (kind)
      KIND_LEV: src = last;
      KIND_EVS: src = status;
      KIND_DET: src = det[det_sel];
      default:  src = '0;
    endcase
    src64 = 64'(src);
  end

  always_comb begin
    read_word = '0;
    if (is_rd) begin
      case (kind) inside
        KIND_FSEL:  read_word = {2'b00, fsel_pad[30*item.reg_index[2:0] +: 30]};
        KIND_LEV, KIND_EVS, KIND_DET: read_word = upper ? src64[63:32] : src64[31:0];
        KIND_PCODE: read_word = {30'h0, pend};
        default:    read_word = '0;
      endcase
    end
  end

  assign latch64 = 64'(latch_next);
  assign en64    = 64'(en_vec);
  assign up64    = 64'(up_vec);
  assign dn64    = 64'(dn_vec);

  assign result.read_data      = read_word;
  assign result.drive_level    = latch64[OUT_PINS-1:0];
  assign result.drive_enable   = en64[OUT_PINS-1:0];
  assign result.pull_up_mask   = up64[OUT_PINS-1:0];
  assign result.pull_down_mask = dn64[OUT_PINS-1:0];
  assign result.event_pending  = |status_next;

`ifndef SYNTHESIS
  a_read_keeps_latch: assert property (@(posedge clk) disable iff (rst)
    step && is_rd |=> $stable(latch))
    else $error("latch changed on a register read");

  a_sample_clears_nothing: assert property (@(posedge clk) disable iff (rst)
    step && is_smp |=> (status & $past(status)) == $past(status))
    else $error("sample cleared an event status bit");

  a_pending_matches: assert property (@(posedge clk) disable iff (rst)
    step |-> result.event_pending == (status_next != '0))
    else $error("event pending flag out of step with status");
`endif

endmodule

// ===== rtl/gpc_out_queue.sv =====
`timescale 1ns / 1ps

module gpc_out_queue
  import gpc_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  rsp_t          push_data,
  output queue_status_t status,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output rsp_t          rsp
);

  rsp_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign pop          = rsp_valid && rsp_ready;
  assign rsp_valid    = count != 2'd0;
  assign rsp          = slots[rd_ptr];
  assign status.full  = count == 2'd2;
  assign status.empty = count == 2'd0;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count == 2'd2 |-> !push)
    else $error("push into a full result queue");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3)
    else $error("result queue count out of range");

  a_ptr_count: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd1) == (wr_ptr != rd_ptr))
    else $error("result queue pointers disagree with count");
`endif

endmodule

// ===== rtl/gpio_pin_controller.sv =====
`timescale 1ns / 1ps

// GPIO controller for PIN_COUNT pins (up to 64, ports fixed at 54 pins).
// Each request transfer is a 32-bit register read, a register write or a
// sample of all pin levels; each one yields exactly one response transfer
// carrying the read word (zero unless a read) and the pin drive, drive
// enable, pull masks and event pending flag as they stand after the item.
// One request is taken every cycle while responses are being taken. A
// request is held in the request register while the register update and
// result logic work on it; when it advances, the result is written into a
// two-entry response queue, from which the response is offered. The queue
// lets the next request in while a finished response still waits; with
// the queue full and a request held, the input stalls until a response
// transfer frees a slot. No clearing pass follows reset.
module gpio_pin_controller
  import gpc_pkg::*;
#(
  parameter int PIN_COUNT = 54
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  // Request register
  logic          stage_valid;
  req_t          stage_item;
  logic          advance;
  rsp_t          result;
  queue_status_t qstat;

  // Advance the held request whenever the response queue has a free slot
  assign advance   = stage_valid && !qstat.full;
  assign req_ready = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else begin
      stage_valid <= (req_valid && req_ready) || (stage_valid && !advance);
    end
  end

  // Hold the payload until the stage advances
  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      stage_item <= req;
    end
  end

  // Register state, decode and result build
  gpc_regfile #(
    .PIN_COUNT (PIN_COUNT)
  ) u_regfile (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .item   (stage_item),
    .result (result)
  );

  // Drop each finished result into the queue in order
  gpc_out_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (advance),
    .push_data (result),
    .status    (qstat),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

`ifndef SYNTHESIS
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    stage_valid && !advance |=> stage_valid && $stable(stage_item))
    else $error("stalled request lost or changed");

  a_full_blocks: assert property (@(posedge clk) disable iff (rst)
    stage_valid && qstat.full |-> !req_ready)
    else $error("request taken with no room downstream");

  a_resp_follows: assert property (@(posedge clk) disable iff (rst)
    advance |=> rsp_valid)
    else $error("advanced request gave no response");

  a_empty_idle: assert property (@(posedge clk) disable iff (rst)
    rsp_valid == !qstat.empty)
    else $error("response valid disagrees with queue state");
`endif

endmodule
